// ===== rtl/ulp_pkg.sv =====
// Shared types, constants and the mu-law expander for the sample reader.
// Used by ulp_front, ulp_fifo, ulp_back and the top level.
`timescale 1ns / 1ps

package ulp_pkg;

  localparam int COUNT_BITS = 24;
  localparam int FMT_BITS = 8;
  localparam int CLIP_BITS = 24;
  localparam int WORD_BITS = 32;
  localparam int SAMPLE_BITS = 16;
  localparam int CFG_INDEX_BITS = 1;
  localparam int CFG_DATA_BITS = 24;
  localparam int FIFO_DEPTH = 2;

  localparam logic [FMT_BITS-1:0] FMT_ULAW = 8'h02;
  localparam logic [FMT_BITS-1:0] FMT_PCM16 = 8'h82;
  localparam logic [COUNT_BITS-1:0] BLOCK_SIZE = COUNT_BITS'(8);

  localparam logic [CFG_INDEX_BITS-1:0] REG_FORMAT = 1'b0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_CLIP = 1'b1;

  localparam logic [2:0] LAST_IDX_ULAW = 3'd7;
  localparam logic [2:0] LAST_IDX_PCM = 3'd3;

  typedef struct packed {
    logic pcm;
    logic cont;
    logic clr;
    logic [WORD_BITS-1:0] word;
  } entry_t;

  function automatic logic signed [SAMPLE_BITS-1:0] ulaw_expand(input logic [7:0] code);
    logic [7:0] u;
    logic [15:0] base;
    logic [15:0] mag;
    u = ~code;
    base = 16'({u[3:0], 3'b000}) + 16'h0084;
    mag = base << u[6:4];
    ulaw_expand = u[7] ? (16'h0084 - mag) : (mag - 16'h0084);
  endfunction

endpackage

// ===== rtl/ulp_fifo.sv =====
// Two-entry queue of classified words between the front and back parts.
// Depends on ulp_pkg for the entry type and depth.
`timescale 1ns / 1ps

module ulp_fifo (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  ulp_pkg::entry_t push_entry,
  output logic            full,
  input  logic            pop,
  output logic            head_valid,
  output ulp_pkg::entry_t head
);

  ulp_pkg::entry_t slots [ulp_pkg::FIFO_DEPTH];
  logic wr_ptr;
  logic rd_ptr;
  logic [1:0] fill;

  assign full = (fill == 2'(ulp_pkg::FIFO_DEPTH));
  assign head_valid = (fill != 2'd0);
  assign head = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        fill <= fill + 2'd1;
      end else if (pop && !push) begin
        fill <= fill - 2'd1;
      end
    end
  end

endmodule

// ===== rtl/ulp_front.sv =====
// Front part: configuration registers, play state and block counting.
// Classifies each accepted item and queues words that produce samples.
// Depends on ulp_pkg.
`timescale 1ns / 1ps

module ulp_front (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [ulp_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [ulp_pkg::CFG_DATA_BITS-1:0]   cfg_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                op,
  input  logic [ulp_pkg::WORD_BITS-1:0]       data_word,
  output logic                                push,
  output ulp_pkg::entry_t                     push_entry,
  input  logic                                full
);

  logic [ulp_pkg::FMT_BITS-1:0] format_code;
  logic [ulp_pkg::CLIP_BITS-1:0] clip_length;
  logic playing;
  logic playing_next;
  logic [ulp_pkg::COUNT_BITS-1:0] remaining_count;
  logic [ulp_pkg::COUNT_BITS-1:0] remaining_count_next;
  logic pcm_second_word;
  logic pcm_second_word_next;
  logic clr_pending;
  logic accept;
  logic is_ulaw;
  logic is_pcm;
  logic block_end;

  assign cfg_ready = 1'b1;
  assign in_stall = full;
  assign accept = in_valid && !in_stall;
  assign is_ulaw = (format_code == ulp_pkg::FMT_ULAW);
  assign is_pcm = (format_code == ulp_pkg::FMT_PCM16);

  always_comb begin
    playing_next = playing;
    remaining_count_next = remaining_count;
    pcm_second_word_next = pcm_second_word;
    block_end = 1'b0;
    push = 1'b0;
    if (accept && op && playing) begin
      if (is_ulaw) begin
        block_end = 1'b1;
        pcm_second_word_next = 1'b0;
        push = 1'b1;
      end else if (is_pcm) begin
        block_end = pcm_second_word;
        pcm_second_word_next = ~pcm_second_word;
        push = 1'b1;
      end else begin
        playing_next = 1'b0;
      end
      if (block_end) begin
        if (remaining_count > ulp_pkg::BLOCK_SIZE) begin
          remaining_count_next = remaining_count - ulp_pkg::BLOCK_SIZE;
        end else begin
          playing_next = 1'b0;
        end
      end
    end
  end

  always_comb begin
    push_entry.pcm = is_pcm;
    push_entry.cont = playing_next;
    push_entry.clr = clr_pending;
    push_entry.word = data_word;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      format_code <= '0;
      clip_length <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        ulp_pkg::REG_FORMAT: format_code <= cfg_data[ulp_pkg::FMT_BITS-1:0];
        ulp_pkg::REG_CLIP: clip_length <= cfg_data[ulp_pkg::CLIP_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      playing <= 1'b0;
      remaining_count <= '0;
      pcm_second_word <= 1'b0;
      clr_pending <= 1'b1;
    end else if (accept && !op) begin
      playing <= 1'b1;
      remaining_count <= ulp_pkg::COUNT_BITS'(clip_length);
      pcm_second_word <= 1'b0;
      clr_pending <= 1'b1;
    end else begin
      playing <= playing_next;
      remaining_count <= remaining_count_next;
      pcm_second_word <= pcm_second_word_next;
      if (push) begin
        clr_pending <= 1'b0;
      end
    end
  end

endmodule

// ===== rtl/ulp_back.sv =====
// Back part: decodes the queued word one sample step per cycle unless stalled,
// inserts the half-sum of neighbors and holds the result in an output register.
// Depends on ulp_pkg.
`timescale 1ns / 1ps

module ulp_back (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    head_valid,
  input  ulp_pkg::entry_t                         head,
  output logic                                    pop,
  output logic                                    out_valid,
  input  logic                                    out_stall,
  output logic signed [ulp_pkg::SAMPLE_BITS-1:0]  sample,
  output logic                                    last_of_word,
  output logic                                    still_playing
);

  logic [2:0] idx;
  logic [1:0] pos;
  logic signed [ulp_pkg::SAMPLE_BITS-1:0] prev;
  logic signed [ulp_pkg::SAMPLE_BITS-1:0] prev_eff;
  logic signed [ulp_pkg::SAMPLE_BITS-1:0] s_cur;
  logic signed [ulp_pkg::SAMPLE_BITS:0] sum;
  logic signed [ulp_pkg::SAMPLE_BITS-1:0] step_sample;
  logic [7:0] code;
  logic [ulp_pkg::SAMPLE_BITS-1:0] half;
  logic step_last;
  logic advance;

  assign pos = idx[2:1];
  assign advance = head_valid && (!out_valid || !out_stall);
  assign pop = advance && step_last;

  always_comb begin
    unique case (pos)
      2'd0: code = head.word[7:0];
      2'd1: code = head.word[15:8];
      2'd2: code = head.word[23:16];
      2'd3: code = head.word[31:24];
      default: code = head.word[7:0];
    endcase
    half = pos[0] ? head.word[31:16] : head.word[15:0];
    s_cur = head.pcm ? $signed(half) : ulp_pkg::ulaw_expand(code);
    prev_eff = (head.clr && pos == 2'd0) ? '0 : prev;
    sum = 17'(prev_eff) + 17'(s_cur);
    step_sample = idx[0] ? s_cur : sum[ulp_pkg::SAMPLE_BITS:1];
    step_last = (idx == (head.pcm ? ulp_pkg::LAST_IDX_PCM : ulp_pkg::LAST_IDX_ULAW));
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      sample <= step_sample;
      last_of_word <= step_last;
      still_playing <= head.cont;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx <= 3'd0;
      prev <= '0;
    end else begin
      if (advance) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (advance) begin
        idx <= step_last ? 3'd0 : idx + 3'd1;
        if (idx[0]) begin
          prev <= s_cur;
        end
      end
    end
  end

`ifndef SYNTHESIS
  a_idle_index: assert property (@(posedge clk) disable iff (rst)
    !head_valid |-> idx == 3'd0)
    else $error("step index left nonzero with the queue empty");
  a_pcm_range: assert property (@(posedge clk) disable iff (rst)
    head_valid && head.pcm |-> !idx[2])
    else $error("PCM word stepped past its fourth sample");
  a_prev_hold: assert property (@(posedge clk) disable iff (rst)
    advance && !idx[0] |=> $stable(prev))
    else $error("previous sample changed on an interpolated step");
`endif

endmodule

// ===== rtl/ulaw_pcm_upsample_reader.sv =====
// Top level of the mu-law / PCM sample reader with 2x interpolation.
// Instantiates ulp_front, ulp_fifo and ulp_back; depends on ulp_pkg.
//
// Usage: write format_code (index 0) and clip_length (index 1) on the cfg
// channel while idle; cfg_ready is always high. On the input channel, op 0 is
// a start item that loads the remaining count and clears the previous sample;
// op 1 carries one 32-bit memory word. An input transfer happens when
// in_valid is high and in_stall low. A mu-law word yields eight samples and a
// PCM word four, one per cycle on the output channel unless out_stall holds them
// (transfer when out_valid is high and out_stall low); last_of_word marks the
// final sample of a word. A word passes through a queue slot and the output
// register before its first sample appears. Start items and words that give
// no samples are taken without entering the queue. A two-entry queue sits
// between front and back, so the front keeps taking words while the receiver
// stalls until the queue fills, then raises in_stall. Reset clears
// configuration, play state, the queue and the output valid flag.
`timescale 1ns / 1ps

module ulaw_pcm_upsample_reader (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    cfg_valid,
  output logic                                    cfg_ready,
  input  logic [ulp_pkg::CFG_INDEX_BITS-1:0]      cfg_index,
  input  logic [ulp_pkg::CFG_DATA_BITS-1:0]       cfg_data,
  input  logic                                    in_valid,
  output logic                                    in_stall,
  input  logic                                    op,
  input  logic [ulp_pkg::WORD_BITS-1:0]           data_word,
  output logic                                    out_valid,
  input  logic                                    out_stall,
  output logic signed [ulp_pkg::SAMPLE_BITS-1:0]  sample,
  output logic                                    last_of_word,
  output logic                                    still_playing
);

  logic push;
  ulp_pkg::entry_t push_entry;
  logic full;
  logic pop;
  logic head_valid;
  ulp_pkg::entry_t head;

  ulp_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .op         (op),
    .data_word  (data_word),
    .push       (push),
    .push_entry (push_entry),
    .full       (full)
  );

  ulp_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  ulp_back u_back (
    .clk           (clk),
    .rst           (rst),
    .head_valid    (head_valid),
    .head          (head),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .sample        (sample),
    .last_of_word  (last_of_word),
    .still_playing (still_playing)
  );

endmodule

// ===== dv/ulp_tb_pkg.sv =====
// Testbench codes for the sample reader: input operations and format codes
// that the design package does not name. Used by ulp_checker and tb.
`timescale 1ns / 1ps

package ulp_tb_pkg;

  localparam logic OP_START = 1'b0;
  localparam logic OP_DATA = 1'b1;

  localparam logic [7:0] FMT_NONE = 8'h00;
  localparam logic [7:0] FMT_UNKNOWN = 8'hFF;

endpackage

// ===== dv/ulp_checker.sv =====
// Checker for the sample reader: tracks configuration writes and input transfers,
// predicts the output samples and compares every output transfer against them.
// Depends on ulp_pkg and ulp_tb_pkg.
`timescale 1ns / 1ps

module ulp_checker
  import ulp_pkg::*;
  import ulp_tb_pkg::*;
(
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [CFG_INDEX_BITS-1:0]      cfg_index,
  input  logic [CFG_DATA_BITS-1:0]       cfg_data,
  input  logic                           in_valid,
  input  logic                           in_stall,
  input  logic                           op,
  input  logic [WORD_BITS-1:0]           data_word,
  input  logic                           out_valid,
  input  logic                           out_stall,
  input  logic signed [SAMPLE_BITS-1:0]  sample,
  input  logic                           last_of_word,
  input  logic                           still_playing,
  input  logic                           drained,
  output int                             fail_count,
  output int                             samples_due
);

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] level;
    logic word_end;
    logic cont;
  } audio_out_t;

  audio_out_t pending_samples[$];

  logic [FMT_BITS-1:0] fmt_reg;
  logic [CLIP_BITS-1:0] clip_reg;
  logic active;
  logic signed [SAMPLE_BITS-1:0] prior;
  logic [COUNT_BITS-1:0] remaining;
  logic half_block;
  int errors = 0;

  function automatic logic signed [SAMPLE_BITS-1:0] mu_decode(input logic [7:0] code);
    logic [7:0] inv;
    int mag;
    inv = ~code;
    mag = ((int'(inv[3:0]) * 8 + 132) << inv[6:4]) - 132;
    return inv[7] ? SAMPLE_BITS'(-mag) : SAMPLE_BITS'(mag);
  endfunction

  function automatic logic signed [SAMPLE_BITS-1:0] midpoint(
    input logic signed [SAMPLE_BITS-1:0] a,
    input logic signed [SAMPLE_BITS-1:0] b
  );
    int total;
    total = int'(a) + int'(b);
    return SAMPLE_BITS'(total >>> 1);
  endfunction

  // Applies one input transfer to the tracked play state and queues the samples it yields.
  function automatic void decode_word(input logic opv, input logic [WORD_BITS-1:0] w);
    logic signed [SAMPLE_BITS-1:0] pts[5];
    int n;
    logic closes;
    audio_out_t item;
    if (opv == OP_START) begin
      remaining = COUNT_BITS'(clip_reg);
      prior = '0;
      half_block = 1'b0;
      active = 1'b1;
      return;
    end
    if (!active) return;
    pts[0] = prior;
    if (fmt_reg == FMT_ULAW) begin
      for (int i = 0; i < 4; i++) pts[i + 1] = mu_decode(w[8 * i +: 8]);
      n = 4;
      closes = 1'b1;
      half_block = 1'b0;
    end else if (fmt_reg == FMT_PCM16) begin
      pts[1] = w[15:0];
      pts[2] = w[31:16];
      n = 2;
      closes = half_block;
      half_block = !half_block;
    end else begin
      active = 1'b0;
      return;
    end
    if (closes) begin
      if (remaining > BLOCK_SIZE) remaining = remaining - BLOCK_SIZE;
      else active = 1'b0;
    end
    for (int i = 1; i <= n; i++) begin
      item.level = midpoint(pts[i - 1], pts[i]);
      item.word_end = 1'b0;
      item.cont = active;
      pending_samples.push_back(item);
      item.level = pts[i];
      item.word_end = (i == n);
      pending_samples.push_back(item);
    end
    prior = pts[n];
  endfunction

  always @(posedge clk) begin
    audio_out_t want;
    if (rst) begin
      fmt_reg = '0;
      clip_reg = '0;
      active = 1'b0;
      prior = '0;
      remaining = '0;
      half_block = 1'b0;
      pending_samples.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (pending_samples.size() == 0) begin
          $error("sample: none expected, got %0d", sample);
          errors++;
        end else begin
          want = pending_samples.pop_front();
          if (sample !== want.level) begin
            $error("sample: expected %0d, got %0d", want.level, sample);
            errors++;
          end
          if (last_of_word !== want.word_end) begin
            $error("last_of_word: expected %0b, got %0b", want.word_end, last_of_word);
            errors++;
          end
          if (still_playing !== want.cont) begin
            $error("still_playing: expected %0b, got %0b", want.cont, still_playing);
            errors++;
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_FORMAT) fmt_reg = cfg_data[FMT_BITS-1:0];
        else if (cfg_index == REG_CLIP) clip_reg = cfg_data[CLIP_BITS-1:0];
      end
      if (in_valid && !in_stall) decode_word(op, data_word);
      if (drained && pending_samples.size() != 0) begin
        $error("sample: %0d expected transfers never arrived", pending_samples.size());
        errors += pending_samples.size();
        pending_samples.delete();
      end
    end
    fail_count <= errors;
    samples_due <= pending_samples.size();
  end

endmodule

// ===== dv/tb.sv =====
// Top of the sample reader testbench: clock, reset, configuration writes,
// directed and random input words, output stalls and the verdict.
// Depends on ulp_pkg, ulp_tb_pkg, ulp_checker and the reader RTL.
`timescale 1ns / 1ps

module tb;
  import ulp_pkg::*;
  import ulp_tb_pkg::*;

  localparam int IDLE_LIMIT = 1000;
  localparam int SETTLE_CYCLES = 20;
  localparam int RANDOM_ITEMS = 320;

  logic clk;
  logic rst;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_INDEX_BITS-1:0] cfg_index;
  logic [CFG_DATA_BITS-1:0] cfg_data;
  logic in_valid;
  logic in_stall;
  logic op;
  logic [WORD_BITS-1:0] data_word;
  logic out_valid;
  logic out_stall;
  logic signed [SAMPLE_BITS-1:0] sample;
  logic last_of_word;
  logic still_playing;
  logic drained;
  logic quiet;
  int fail_count;
  int samples_due;
  int stall_left = 0;
  int idle_cycles = 0;

  ulaw_pcm_upsample_reader u_top (
    .clk(clk),
    .rst(rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .op(op),
    .data_word(data_word),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .sample(sample),
    .last_of_word(last_of_word),
    .still_playing(still_playing)
  );

  ulp_checker u_chk (
    .clk(clk),
    .rst(rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .op(op),
    .data_word(data_word),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .sample(sample),
    .last_of_word(last_of_word),
    .still_playing(still_playing),
    .drained(drained),
    .fail_count(fail_count),
    .samples_due(samples_due)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst || quiet) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left = stall_left - 1;
    end else if ($urandom_range(0, 7) == 0) begin
      out_stall <= 1'b1;
      stall_left = $urandom_range(0, 14);
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  task automatic send_item(input logic opv, input logic [WORD_BITS-1:0] w);
    int gap;
    if (!quiet && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 15);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    op <= opv;
    data_word <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // The bits above the format byte are random so that the write must ignore them.
  task automatic program_regs(input logic [FMT_BITS-1:0] fmt,
                              input logic [CLIP_BITS-1:0] clip);
    write_reg(REG_FORMAT, {16'($urandom), fmt});
    write_reg(REG_CLIP, clip);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    repeat (2) @(posedge clk);
    while (samples_due != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic int clip_words(input logic [FMT_BITS-1:0] fmt,
                                    input logic [CLIP_BITS-1:0] clip);
    int blocks;
    blocks = (clip <= 8) ? 1 : (int'(clip) + 7) / 8;
    if (fmt == FMT_ULAW) return blocks;
    if (fmt == FMT_PCM16) return 2 * blocks;
    return 1;
  endfunction

  initial begin
    int useful;
    int runs;
    int n;
    int pick;
    logic [FMT_BITS-1:0] fmt;
    logic [CLIP_BITS-1:0] clip;

    rst = 1'b1;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    op = OP_START;
    data_word = '0;
    drained = 1'b0;
    quiet = 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // A word before any start is dropped.
    send_item(OP_DATA, 32'h12345678);
    settle();
    program_regs(FMT_ULAW, 24'd24);
    send_item(OP_START, '0);
    send_item(OP_DATA, 32'h7F80FF00);
    send_item(OP_DATA, 32'hFFFFFFFF);
    send_item(OP_DATA, 32'h00000000);
    send_item(OP_DATA, 32'h807F01FE);
    settle();
    program_regs(FMT_PCM16, 24'd9);
    send_item(OP_START, '0);
    send_item(OP_DATA, 32'h80007FFF);
    send_item(OP_DATA, 32'h7FFF8000);
    send_item(OP_DATA, 32'hFFFF0001);
    // Switching to mu-law after half a PCM block.
    settle();
    program_regs(FMT_ULAW, 24'd9);
    send_item(OP_DATA, 32'h01FE807F);
    settle();
    program_regs(FMT_PCM16, 24'd0);
    send_item(OP_START, '0);
    send_item(OP_DATA, 32'h00000000);
    send_item(OP_DATA, 32'hFFFFFFFF);
    settle();
    program_regs(FMT_UNKNOWN, 24'hFFFFFF);
    send_item(OP_START, '0);
    send_item(OP_DATA, $urandom);
    send_item(OP_DATA, $urandom);
    settle();
    program_regs(FMT_NONE, 24'hFFFFFF);
    send_item(OP_START, '0);
    send_item(OP_DATA, $urandom);
    settle();
    program_regs(FMT_ULAW, 24'hFFFFFF);
    send_item(OP_START, '0);
    send_item(OP_DATA, $urandom);
    send_item(OP_START, '0);
    send_item(OP_DATA, $urandom);

    useful = 0;
    while (useful < RANDOM_ITEMS) begin
      if (useful >= RANDOM_ITEMS - 70) quiet <= 1'b1;
      settle();
      pick = $urandom_range(0, 9);
      if (pick < 4) fmt = FMT_ULAW;
      else if (pick < 8) fmt = FMT_PCM16;
      else if (pick == 8) fmt = FMT_NONE;
      else fmt = 8'($urandom);
      pick = $urandom_range(0, 9);
      case (pick)
        0: clip = 24'd0;
        1: clip = 24'd8;
        2: clip = 24'd9;
        3: clip = 24'hFFFFFF;
        4: clip = 24'($urandom);
        default: clip = 24'($urandom_range(1, 120));
      endcase
      program_regs(fmt, clip);
      runs = $urandom_range(1, 3);
      repeat (runs) begin
        if ($urandom_range(0, 4) != 0) begin
          send_item(OP_START, 32'($urandom));
          useful++;
        end
        n = $urandom_range(3, 20);
        if (n > clip_words(fmt, clip)) n = clip_words(fmt, clip);
        repeat (n) begin
          if ($urandom_range(0, 19) == 0) send_item(OP_START, 32'($urandom));
          send_item(OP_DATA, $urandom);
          useful++;
        end
        if ($urandom_range(0, 2) == 0) send_item(OP_DATA, $urandom);
      end
    end

    in_valid <= 1'b0;
    repeat (2) @(posedge clk);
    while (samples_due != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    drained <= 1'b1;
    repeat (2) @(posedge clk);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
